>>> rtl/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared constants for the ordered list block: sizes, opcodes and status codes
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

endpackage

>>> rtl/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of signed 32-bit values with insert, delete and display
// ----------------------------------------------------------------------------
// The list is held compacted in a 16-entry memory from the head, with a fill
// count in flip-flops, so no clearing pass follows reset. One request is
// worked on at a time; a finished response waits in an output register while
// the next request is taken. Delete walks the memory one entry a cycle
// through its single read port, first to find the match and then to shift
// each later entry down. Display emits one entry a cycle while the output
// does not stall. Empty, full and not-found cases answer with one response.
module ordered_list_insert_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] item, [33:32] status, zero pad
  output logic        m_axis_tlast_o
);

  localparam int IW = olid_pkg::IDX_W;
  localparam int CW = olid_pkg::CNT_W;
  localparam int DW = olid_pkg::DATA_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RESP  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DISP  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] val_q, val_d;
  logic [1:0]    st_q, st_d;

  logic          ovalid_q, ovalid_d;
  logic [DW-1:0] oitem_q, oitem_d;
  logic [1:0]    ostat_q, ostat_d;
  logic          olast_q, olast_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic          can_load, in_acc, is_last;
  logic [IW-1:0] idx_nxt;

  olid_ram #(
    .DEPTH(olid_pkg::CAPACITY),
    .WIDTH(DW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign can_load        = !ovalid_q || m_axis_tready_i;
  assign idx_nxt         = idx_q + IW'(1);
  assign is_last         = (CW'(idx_q) == (cnt_q - CW'(1)));

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    val_d     = val_q;
    st_d      = st_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q - IW'(1);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_nxt;
    ovalid_d  = ovalid_q && !m_axis_tready_i;
    oitem_d   = oitem_q;
    ostat_d   = ostat_q;
    olast_d   = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          val_d = s_axis_tdata_i;
          unique case (s_axis_tuser_i) inside
            olid_pkg::OP_INSERT: begin
              state_d = S_RESP;
              if (cnt_q == CW'(olid_pkg::CAPACITY)) begin
                st_d = olid_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[IW-1:0];
                ram_wdata = s_axis_tdata_i;
                cnt_d     = cnt_q + CW'(1);
                st_d      = olid_pkg::ST_OK;
              end
            end
            olid_pkg::OP_DELETE, olid_pkg::OP_DISPLAY: begin
              if (cnt_q == '0) begin
                st_d    = olid_pkg::ST_EMPTY;
                state_d = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = (s_axis_tuser_i == olid_pkg::OP_DELETE) ? S_SRCH : S_DISP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RESP: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          oitem_d  = '0;
          ostat_d  = st_q;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_SRCH: begin
        if (ram_rdata == val_q) begin
          if (is_last) begin
            cnt_d   = cnt_q - CW'(1);
            st_d    = olid_pkg::ST_OK;
            state_d = S_RESP;
          end else begin
            ram_re  = 1'b1;
            idx_d   = idx_nxt;
            state_d = S_SHIFT;
          end
        end else if (is_last) begin
          st_d    = olid_pkg::ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_nxt;
        end
      end
      S_SHIFT: begin
        ram_we = 1'b1;
        if (is_last) begin
          cnt_d   = cnt_q - CW'(1);
          st_d    = olid_pkg::ST_OK;
          state_d = S_RESP;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_nxt;
        end
      end
      S_DISP: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          oitem_d  = ram_rdata;
          ostat_d  = olid_pkg::ST_OK;
          olast_d  = is_last;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            ram_re = 1'b1;
            idx_d  = idx_nxt;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    val_q   <= val_d;
    st_q    <= st_d;
    oitem_q <= oitem_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'b0, ostat_q, oitem_q};
  assign m_axis_tlast_o  = olast_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(olid_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_shift_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (idx_q != '0))
    else $error("shift step at head position");

  a_insert_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == olid_pkg::OP_INSERT &&
     cnt_q != CW'(olid_pkg::CAPACITY)) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow the list");

  a_walk_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH || state_q == S_DISP) |-> (cnt_q != '0))
    else $error("memory walk on empty list");
`endif

endmodule

>>> rtl/olid_ram.sv
// ----------------------------------------------------------------------------
// olid_ram
// Simple dual-port RAM, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module olid_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/ordered_list_response_checker.sv
// ----------------------------------------------------------------------------
// ordered_list_response_checker
// Watches both stream channels of the ordered list block, keeps its own copy
// of the list to work out the responses of every accepted request, and
// compares each accepted response field by field with the oldest one due.
// ----------------------------------------------------------------------------
module ordered_list_response_checker
  import olid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // [31:0] item, [33:32] status, zero pad
  input  logic        m_axis_tlast_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] item;
    logic [1:0]  status;
    logic        last;
  } response_t;

  response_t   due_q[$];
  logic [31:0] list_mem [CAPACITY];
  int          list_len = 0;
  int          mismatches = 0;

  assign errors_o = mismatches;

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  task automatic push_response(input logic [31:0] item, input logic [1:0] status,
                               input logic last);
    response_t r;
    r.item   = item;
    r.status = status;
    r.last   = last;
    due_q.push_back(r);
  endtask

  // update the list copy and queue the responses of one request
  task automatic apply_request(input logic [1:0] op, input logic [31:0] val);
    int pos;
    pos = -1;
    case (op)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          push_response('0, ST_FULL, 1'b1);
        end else begin
          list_mem[list_len] = val;
          list_len++;
          push_response('0, ST_OK, 1'b1);
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          push_response('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (pos < 0 && list_mem[i] == val) pos = i;
          end
          if (pos < 0) begin
            push_response('0, ST_NOT_FOUND, 1'b1);
          end else begin
            for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
            push_response('0, ST_OK, 1'b1);
          end
        end
      end
      OP_DISPLAY: begin
        if (list_len == 0) begin
          push_response('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            push_response(list_mem[i], ST_OK, i == list_len - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    response_t want;
    if (!rst_ni) begin
      list_len = 0;
      due_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_q.size() == 0) begin
          note_mismatch("unexpected response item", '0, m_axis_tdata_i[31:0]);
        end else begin
          want = due_q.pop_front();
          if (m_axis_tdata_i[31:0] !== want.item)
            note_mismatch("item", want.item, m_axis_tdata_i[31:0]);
          if (m_axis_tdata_i[33:32] !== want.status)
            note_mismatch("status", 32'(want.status), 32'(m_axis_tdata_i[33:32]));
          if (m_axis_tlast_i !== want.last)
            note_mismatch("last", 32'(want.last), 32'(m_axis_tlast_i));
          if (m_axis_tdata_i[39:34] !== '0)
            note_mismatch("pad", '0, 32'(m_axis_tdata_i[39:34]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_request(s_axis_tuser_i, s_axis_tdata_i);
      end
      pending_o <= due_q.size();
    end
  end

endmodule

>>> tb/ordered_list_insert_delete_test.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_test
// Drives insert, delete and display requests into the ordered list block:
// a directed opening over empty, full, duplicate and extreme values, then
// random requests in phases of sender gaps and receiver stalls, with one long
// receiver hold-off. A separate checker predicts and compares the responses.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_test;
  import olid_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_ITEMS  = 70;
  localparam int BURST_ITEMS  = 20;
  localparam int POOL_DEPTH   = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [31:0] value
  logic [1:0]  s_axis_tuser_i = '0;   // [1:0] opcode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] item, [33:32] status, zero pad
  logic        m_axis_tlast_o;

  int          errors;
  int          pending;
  int          sender_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          cycle_count = 0;
  logic [31:0] value_pool[$];

  ordered_list_insert_delete dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  ordered_list_response_checker response_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[ordered_list_insert_delete] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, and a long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_served != hold_requests) begin
      hold_served++;
      m_axis_tready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
    end
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [31:0] random_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3, 4, 5: return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= val;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op == OP_INSERT) begin
      value_pool.push_back(val);
      if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
    end
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // deletes mostly target values that were inserted recently
  task automatic run_random(input int n);
    int          r;
    logic [1:0]  op;
    logic [31:0] val;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45) op = OP_INSERT;
      else if (r < 75) op = OP_DELETE;
      else if (r < 95) op = OP_DISPLAY;
      else op = OP_UNUSED;
      if (op == OP_DELETE && value_pool.size() != 0 && $urandom_range(99) < 65)
        val = value_pool[$urandom_range(value_pool.size() - 1)];
      else
        val = random_value();
      send_request(op, val);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, ignored opcode, extremes and duplicates
    send_request(OP_DISPLAY, 32'h0000_0000);
    send_request(OP_DELETE, 32'h0000_0005);
    send_request(OP_UNUSED, 32'hffff_ffff);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h7fff_ffff);
    send_request(OP_INSERT, 32'h0000_0007);
    send_request(OP_INSERT, 32'hffff_ffff);
    send_request(OP_INSERT, 32'h0000_0007);
    send_request(OP_DELETE, 32'h0000_3039);
    send_request(OP_DELETE, 32'h0000_0007);
    send_request(OP_DELETE, 32'h8000_0000);
    // fill up, overflow and list the full store
    repeat (CAPACITY - 3) send_request(OP_INSERT, random_value());
    send_request(OP_INSERT, 32'h1234_5678);
    send_request(OP_DISPLAY, 32'hffff_ffff);
    wait_for_drain();

    sender_idle_pct = 0;
    sink_stall_pct <= 0;
    run_random(PHASE_ITEMS);
    wait_for_drain();

    sender_idle_pct = 65;
    run_random(PHASE_ITEMS);
    wait_for_drain();

    sender_idle_pct = 0;
    sink_stall_pct <= 65;
    run_random(PHASE_ITEMS);
    wait_for_drain();

    sender_idle_pct = 28;
    sink_stall_pct <= 28;
    run_random(PHASE_ITEMS);
    wait_for_drain();

    // receiver holds off while requests keep coming
    sender_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    run_random(BURST_ITEMS);
    wait_for_drain();

    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[ordered_list_insert_delete] OK");
    end else begin
      $display("[ordered_list_insert_delete] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/olid_pkg.sv
rtl/olid_ram.sv
rtl/ordered_list_insert_delete.sv
tb/ordered_list_response_checker.sv
tb/ordered_list_insert_delete_test.sv
